@@ sv/assert_macros.svh @@
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication, quiet during reset
`define PGS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, quiet during reset
`define PGS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PGS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PGS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ sv/pgs_pkg.sv @@
// constants, stage record and per-stage datapath of the polar gaussian sampler
`default_nettype none
package pgs_pkg;

  localparam int UNIFORM_BITS = 24;
  localparam int UW = UNIFORM_BITS;
  localparam int SW = 2 * UNIFORM_BITS;

  localparam logic [UW-1:0] HALF  = {1'b1, {(UW-1){1'b0}}};
  localparam logic [SW-1:0] LIMIT = {2'b01, {(SW-2){1'b0}}};
  localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AC;

  // stage map
  localparam int ST_PREP    = 0;
  localparam int ST_SQ      = 1;
  localparam int ST_SUM     = 2;
  localparam int ST_NORM    = 3;
  localparam int ST_LOG0    = 4;
  localparam int LOG_SUBS   = 112;
  localparam int DIV_STEPS  = 62;
  localparam int ST_T       = ST_LOG0 + LOG_SUBS;
  localparam int ST_LM1     = ST_T + 1;
  localparam int ST_LM2     = ST_T + 2;
  localparam int ST_GM1     = ST_T + 3;
  localparam int ST_GM2     = ST_T + 4;
  localparam int ST_SQRT0   = ST_T + 5;
  localparam int SQRT_STEPS = 32;
  localparam int ST_RND     = ST_SQRT0 + SQRT_STEPS;
  localparam int ST_SIG     = ST_RND + 1;
  localparam int ST_OUT     = ST_RND + 2;
  localparam int NUM_STAGES = ST_OUT + 1;

  typedef struct packed {
    logic [UW-1:0]       aa;
    logic [UW-1:0]       ab;
    logic                neg;
    logic [23:0]         sigma;
    logic signed [31:0]  center;
    logic [SW-1:0]       a2;
    logic [SW-1:0]       b2;
    logic [SW-1:0]       s;
    logic                keep;
    logic [SW:0]         r;
    logic [63:0]         q;
    logic [5:0]          e;
    logic [63:0]         m;
    logic [55:0]         frac;
    logic [63:0]         p0;
    logic [63:0]         p1;
    logic [63:0]         p2;
    logic [63:0]         p3;
    logic [63:0]         tval;
    logic [63:0]         lval;
    logic [63:0]         n;
    logic [63:0]         res;
    logic [55:0]         prod;
    logic [31:0]         sample;
  } stage_t;

  // work done between register idx-1 and register idx
  function automatic stage_t pgs_stage(input stage_t d, input int idx);
    stage_t o;
    logic [127:0] wide;
    logic [63:0] mnew;
    logic [64:0] trial;
    logic [63:0] bitv;
    logic [SW:0] rr;
    logic [56:0] rsum;
    logic [28:0] mag;
    logic signed [33:0] total;
    logic [5:0] lead;
    int j;
    o = d; wide = '0; mnew = '0; trial = '0; bitv = '0; rr = '0;
    rsum = '0; mag = '0; total = '0; lead = '0; j = 0;
    if (idx == ST_PREP) begin
      o.neg = (d.ab < HALF);
      o.aa  = (d.aa >= HALF) ? d.aa - HALF : HALF - d.aa;
      o.ab  = (d.ab >= HALF) ? d.ab - HALF : HALF - d.ab;
    end else if (idx == ST_SQ) begin
      o.a2 = SW'(d.aa) * SW'(d.aa);
      o.b2 = SW'(d.ab) * SW'(d.ab);
    end else if (idx == ST_SUM) begin
      o.s    = d.a2 + d.b2;
      o.keep = (o.s != '0) && (o.s <= LIMIT);
      o.r    = {1'b0, d.b2};
    end else if (idx == ST_NORM) begin
      for (int k = 0; k < SW; k++) begin
        if (d.s[k]) lead = 6'(k);
      end
      o.e = lead;
      o.m = 64'(d.s) << (6'd62 - lead);
      o.frac = '0;
      o.q = '0;
      if (d.r >= {1'b0, d.s}) begin
        o.q[0] = 1'b1;
        o.r = d.r - {1'b0, d.s};
      end
    end else if (idx >= ST_LOG0 && idx < ST_T) begin
      j = idx - ST_LOG0;
      // long division for y^2 / s, one quotient bit per stage
      if (j < DIV_STEPS) begin
        rr = d.r << 1;
        o.q = d.q << 1;
        if (rr >= {1'b0, d.s}) begin
          rr = rr - {1'b0, d.s};
          o.q[0] = 1'b1;
        end
        o.r = rr;
      end
      // log2 fraction by repeated squaring, two stages per bit
      if ((j % 2) == 0) begin
        o.p0 = 64'(d.m[63:32]) * 64'(d.m[63:32]);
        o.p1 = 64'(d.m[63:32]) * 64'(d.m[31:0]);
        o.p2 = 64'(d.m[31:0]) * 64'(d.m[31:0]);
      end else begin
        wide = {d.p0, 64'd0} + (128'(d.p1) << 33) + 128'(d.p2);
        mnew = wide[125:62];
        o.frac = {d.frac[54:0], mnew[63]};
        o.m = mnew[63] ? (mnew >> 1) : mnew;
      end
    end else if (idx == ST_T) begin
      o.tval = (64'(SW - 2) << 56) - 64'({d.e, d.frac});
    end else if (idx == ST_LM1) begin
      o.p0 = 64'(d.tval[63:32]) * 64'(LN2_Q64[63:32]);
      o.p1 = 64'(d.tval[63:32]) * 64'(LN2_Q64[31:0]);
      o.p2 = 64'(d.tval[31:0]) * 64'(LN2_Q64[63:32]);
      o.p3 = 64'(d.tval[31:0]) * 64'(LN2_Q64[31:0]);
    end else if (idx == ST_LM2) begin
      wide = {d.p0, 64'd0} + (128'(d.p1) << 32) + (128'(d.p2) << 32) + 128'(d.p3);
      o.lval = wide[126:63];
    end else if (idx == ST_GM1) begin
      o.p0 = 64'(d.q[63:32]) * 64'(d.lval[63:32]);
      o.p1 = 64'(d.q[63:32]) * 64'(d.lval[31:0]);
      o.p2 = 64'(d.q[31:0]) * 64'(d.lval[63:32]);
      o.p3 = 64'(d.q[31:0]) * 64'(d.lval[31:0]);
    end else if (idx == ST_GM2) begin
      wide = {d.p0, 64'd0} + (128'(d.p1) << 32) + (128'(d.p2) << 32) + 128'(d.p3);
      o.n = wide[125:62];
      o.res = '0;
    end else if (idx >= ST_SQRT0 && idx < ST_RND) begin
      j = idx - ST_SQRT0;
      bitv = 64'd1 << (62 - 2 * j);
      trial = 65'(d.res) + 65'(bitv);
      if (65'(d.n) >= trial) begin
        o.n = d.n - trial[63:0];
        o.res = (d.res >> 1) + bitv;
      end else begin
        o.res = d.res >> 1;
      end
    end else if (idx == ST_RND) begin
      if (d.n > d.res) o.res = d.res + 64'd1;
    end else if (idx == ST_SIG) begin
      o.prod = 56'(d.sigma) * 56'(d.res[31:0]);
    end else if (idx == ST_OUT) begin
      rsum = 57'(d.prod) + (57'd1 << 27);
      mag = rsum[56:28];
      if (d.neg) begin
        total = 34'(d.center) - $signed({5'd0, mag});
      end else begin
        total = 34'(d.center) + $signed({5'd0, mag});
      end
      if (total > 34'sd2147483647) begin
        o.sample = 32'h7FFF_FFFF;
      end else if (total < -34'sd2147483648) begin
        o.sample = 32'h8000_0000;
      end else begin
        o.sample = total[31:0];
      end
    end
    return o;
  endfunction

endpackage
`default_nettype wire

@@ sv/pgs_in_if.sv @@
// input channel: a uniform pair plus spread and center
`default_nettype none
interface pgs_in_if;
  logic                 valid;
  logic                 ready;
  logic [pgs_pkg::UW-1:0] uniform_a;
  logic [pgs_pkg::UW-1:0] uniform_b;
  logic [23:0]          spread;
  logic signed [31:0]   mean_value;
  modport source (output valid, uniform_a, uniform_b, spread, mean_value, input ready);
  modport sink (input valid, uniform_a, uniform_b, spread, mean_value, output ready);
endinterface
`default_nettype wire

@@ sv/pgs_out_if.sv @@
// result channel: one gaussian sample
`default_nettype none
interface pgs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_out;
  modport source (output valid, sample_out, input ready);
  modport sink (input valid, sample_out, output ready);
endinterface
`default_nettype wire

@@ sv/polar_gaussian_sample.sv @@
// polar gaussian sampler top level
//
// in_bus takes one transaction per cycle while ready is high: two uniform
// codes, the spread (sigma, unsigned q8.16) and the center (signed q16.16).
// out_bus gives one transaction for each pair inside the unit circle and
// none for pairs outside it or at the origin; order is kept.
// the log2 chain is the longest part: 56 squaring steps, two register
// stages each. throughput is one transaction per cycle unless the receiver
// stalls; division and log run side by side in the same stages, the
// square root takes one bit per stage.
// reset empties the pipeline (valid bits only); data registers are not reset.
// when the receiver stalls with a result waiting, every stage holds and
// in_bus.ready drops in the same cycle; rejected pairs never stall it.
`default_nettype none
module polar_gaussian_sample (
  input  logic      clk,
  input  logic      rst_n,
  pgs_in_if.sink    in_bus,
  pgs_out_if.source out_bus
);

  localparam int N = pgs_pkg::NUM_STAGES;

  pgs_pkg::stage_t        head;
  pgs_pkg::stage_t        pipe_r   [N];
  pgs_pkg::stage_t        pipe_nxt [N];
  logic [N-1:0]           vld_r;
  logic                   advance;

  // incoming transaction into stage record
  always_comb begin
    head = '0;
    head.aa = in_bus.uniform_a;
    head.ab = in_bus.uniform_b;
    head.sigma = in_bus.spread;
    head.center = in_bus.mean_value;
  end

  // whole pipe moves unless a kept result waits at the output
  assign advance = !out_bus.valid || out_bus.ready;
  assign in_bus.ready = advance;

  for (genvar g = 0; g < N; g++) begin : g_stage
    if (g == 0) begin : g_first
      assign pipe_nxt[g] = pgs_pkg::pgs_stage(head, g);
    end else begin : g_rest
      assign pipe_nxt[g] = pgs_pkg::pgs_stage(pipe_r[g-1], g);
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (advance) begin
      vld_r <= {vld_r[N-2:0], in_bus.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pipe_r <= pipe_nxt;
    end
  end

  // rejected pairs fall out silently
  assign out_bus.valid = vld_r[N-1] && pipe_r[N-1].keep;
  assign out_bus.sample_out = pipe_r[N-1].sample;

  `include "assert_macros.svh"

  `PGS_ASSERT_NEXT(a_stall_holds, clk, rst_n, !advance, $stable(vld_r))
  `PGS_ASSERT_IMP(a_inside_circle, clk, rst_n, out_bus.valid, (pipe_r[N-1].s != '0) && (pipe_r[N-1].s <= pgs_pkg::LIMIT))
  `PGS_ASSERT_IMP(a_zero_y, clk, rst_n, out_bus.valid && (pipe_r[N-1].ab == '0), out_bus.sample_out == pipe_r[N-1].center)

endmodule
`default_nettype wire
